>>> rtl/mmh_pkg.sv
`timescale 1ns / 1ps

package mmh_pkg;

  localparam logic [63:0] MIX_MUL   = 64'hc6a4a7935bd1e995;
  localparam int          MIX_SHIFT = 47;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [3:0] FULL_COUNT = 4'd8;

  typedef struct packed {
    logic [63:0] data_word;
    logic [63:0] total_length;
    logic        is_first;
    logic        is_last;
    logic        mix_full;
    logic        mix_tail;
    logic        length_mismatch;
  } ent_t;

  typedef enum logic [7:0] {
    BK_IDLE = 8'b0000_0001,
    BK_INIT = 8'b0000_0010,
    BK_K1   = 8'b0000_0100,
    BK_K2   = 8'b0000_1000,
    BK_H1   = 8'b0001_0000,
    BK_TAIL = 8'b0010_0000,
    BK_FIN  = 8'b0100_0000,
    BK_OUT  = 8'b1000_0000
  } bk_state_e;

  typedef enum logic [3:0] {
    MUL_IDLE = 4'b0001,
    MUL_LL   = 4'b0010,
    MUL_LH   = 4'b0100,
    MUL_HL   = 4'b1000
  } mul_state_e;

  function automatic logic [63:0] tail_mask(input logic [2:0] n);
    logic [5:0] sh;
    sh = {n, 3'b000};
    return ~(64'hffff_ffff_ffff_ffff << sh);
  endfunction

  function automatic logic [63:0] fold(input logic [63:0] v);
    return v ^ (v >> MIX_SHIFT);
  endfunction

endpackage

>>> rtl/mmh_if.sv
`timescale 1ns / 1ps

interface mmh_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_word;
  logic [3:0]  byte_count;
  logic        is_first;
  logic        is_last;
  logic [63:0] total_length;

  modport source (output valid, data_word, byte_count, is_first, is_last, total_length,
                  input ready);
  modport sink (input valid, data_word, byte_count, is_first, is_last, total_length,
                output ready);
endinterface

interface mmh_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_value;
  logic        length_mismatch;

  modport source (output valid, hash_value, length_mismatch, input ready);
  modport sink (input valid, hash_value, length_mismatch, output ready);
endinterface

>>> rtl/murmur_hash_64_unit.sv
`timescale 1ns / 1ps
// channel   | dir | handshake     | payload
// ----------+-----+---------------+---------------------------------------------------
// in_ch_i   | in  | valid / ready | data_word, byte_count, is_first, is_last,
//           |     |               | total_length
// out_ch_o  | out | valid / ready | hash_value, length_mismatch
// cfg       | in  | cfg_we_i      | cfg_wdata_i (seed)
//
// every 64-bit multiply by the mixing constant runs on one shared 32x32 multiplier in
// three steps; a full word takes 3 of them, and the back end works on one item at a time
// a first item adds one more multiply, a tail adds one, the final avalanche adds one more
// a two-entry queue lets the input side keep taking items while the back end or the
// output stalls; reset clears all control state at once, no clearing pass

module murmur_hash_64_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [63:0] cfg_wdata_i,
  mmh_in_if.sink      in_ch_i,
  mmh_out_if.source   out_ch_o
);

  logic          q_full, q_push, q_pop, q_valid;
  mmh_pkg::ent_t push_ent, pop_ent;

  mmh_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch_i    (in_ch_i),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .push_ent_o (push_ent)
  );

  mmh_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_ent_i (push_ent),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_ent_o  (pop_ent)
  );

  mmh_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_valid_i   (q_valid),
    .q_ent_i     (pop_ent),
    .pop_o       (q_pop),
    .out_ch_o    (out_ch_o)
  );

endmodule

>>> rtl/mmh_mul.sv
`timescale 1ns / 1ps

module mmh_mul (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] a_i,
  output logic        done_o,
  output logic [63:0] p_o
);

  mmh_pkg::mul_state_e state_q, state_d;
  logic [63:0] a_q;
  logic [63:0] acc_q;
  logic        done_q;
  logic [31:0] op_a, op_b;
  logic [63:0] prod;

  always_comb begin
    op_a  = (state_q == mmh_pkg::MUL_HL) ? a_q[63:32] : a_q[31:0];
    op_b  = (state_q == mmh_pkg::MUL_LH) ? mmh_pkg::MIX_MUL[63:32] : mmh_pkg::MIX_MUL[31:0];
    prod  = op_a * op_b;
    state_d = state_q;
    case (state_q)
      mmh_pkg::MUL_IDLE: if (start_i) state_d = mmh_pkg::MUL_LL;
      mmh_pkg::MUL_LL:   state_d = mmh_pkg::MUL_LH;
      mmh_pkg::MUL_LH:   state_d = mmh_pkg::MUL_HL;
      mmh_pkg::MUL_HL:   state_d = mmh_pkg::MUL_IDLE;
      default:           state_d = mmh_pkg::MUL_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mmh_pkg::MUL_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == mmh_pkg::MUL_HL);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == mmh_pkg::MUL_IDLE && start_i) begin
      a_q <= a_i;
    end
    case (state_q)
      mmh_pkg::MUL_LL: acc_q <= prod;
      mmh_pkg::MUL_LH,
      mmh_pkg::MUL_HL: acc_q[63:32] <= acc_q[63:32] + prod[31:0];
      default:         acc_q <= acc_q;
    endcase
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

>>> rtl/mmh_queue.sv
`timescale 1ns / 1ps

module mmh_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mmh_pkg::ent_t push_ent_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output mmh_pkg::ent_t pop_ent_o
);

  mmh_pkg::ent_t mem_q [mmh_pkg::QUEUE_DEPTH];
  logic [mmh_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [mmh_pkg::QCNT_W-1:0] cnt_q;

  localparam logic [mmh_pkg::QPTR_W-1:0] LAST_PTR =
    mmh_pkg::QPTR_W'(mmh_pkg::QUEUE_DEPTH - 1);
  localparam logic [mmh_pkg::QCNT_W-1:0] DEPTH_CNT =
    mmh_pkg::QCNT_W'(mmh_pkg::QUEUE_DEPTH);

  logic do_push, do_pop;

  assign full_o    = (cnt_q == DEPTH_CNT);
  assign valid_o   = (cnt_q != '0);
  assign pop_ent_o = mem_q[rd_ptr_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_ent_i;
    end
  end

endmodule

>>> rtl/mmh_front.sv
`timescale 1ns / 1ps

module mmh_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  mmh_in_if.sink        in_ch_i,
  input  logic          q_full_i,
  output logic          push_o,
  output mmh_pkg::ent_t push_ent_o
);

  logic [63:0] declared_q, declared_d;
  logic [63:0] seen_q, seen_d;
  logic [63:0] dl, bs;
  logic [3:0]  cnt;
  logic        xfer;

  assign in_ch_i.ready = !q_full_i;
  assign xfer          = in_ch_i.valid && !q_full_i;
  assign push_o        = xfer;

  always_comb begin
    cnt = (in_ch_i.byte_count > mmh_pkg::FULL_COUNT) ? mmh_pkg::FULL_COUNT
                                                     : in_ch_i.byte_count;
    dl  = in_ch_i.is_first ? in_ch_i.total_length : declared_q;
    bs  = in_ch_i.is_first ? 64'd0 : seen_q;

    push_ent_o.total_length    = in_ch_i.total_length;
    push_ent_o.is_first        = in_ch_i.is_first;
    push_ent_o.is_last         = in_ch_i.is_last;
    push_ent_o.mix_full        = !in_ch_i.is_last || (cnt == mmh_pkg::FULL_COUNT);
    push_ent_o.mix_tail        = in_ch_i.is_last && (cnt != mmh_pkg::FULL_COUNT) &&
                                 (cnt != 4'd0);
    push_ent_o.data_word       = push_ent_o.mix_full ? in_ch_i.data_word
                               : (in_ch_i.data_word & mmh_pkg::tail_mask(cnt[2:0]));
    push_ent_o.length_mismatch = ((bs + {60'd0, cnt}) != dl);

    if (in_ch_i.is_last) begin
      declared_d = 64'd0;
      seen_d     = 64'd0;
    end else begin
      declared_d = dl;
      seen_d     = bs + 64'd8;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      declared_q <= 64'd0;
      seen_q     <= 64'd0;
    end else if (xfer) begin
      declared_q <= declared_d;
      seen_q     <= seen_d;
    end
  end

endmodule

>>> rtl/mmh_back.sv
`timescale 1ns / 1ps

module mmh_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [63:0]   cfg_wdata_i,
  input  logic          q_valid_i,
  input  mmh_pkg::ent_t q_ent_i,
  output logic          pop_o,
  mmh_out_if.source     out_ch_o
);

  mmh_pkg::bk_state_e state_q, state_d;
  mmh_pkg::ent_t ent_q;
  logic [63:0] seed_q;
  logic [63:0] h_q, k_q;
  logic        pend_q;
  logic        out_valid_q;
  logic [63:0] out_hash_q;
  logic        out_mis_q;
  logic        mul_state, mul_start, mul_done;
  logic [63:0] mul_a, mul_p;
  logic        out_free;

  function automatic mmh_pkg::bk_state_e after_init(input mmh_pkg::ent_t e);
    if (e.mix_full)      return mmh_pkg::BK_K1;
    else if (e.mix_tail) return mmh_pkg::BK_TAIL;
    else if (e.is_last)  return mmh_pkg::BK_FIN;
    else                 return mmh_pkg::BK_IDLE;
  endfunction

  mmh_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  assign out_free = !out_valid_q || out_ch_o.ready;
  assign pop_o    = (state_q == mmh_pkg::BK_IDLE) && q_valid_i;

  always_comb begin
    mul_state = 1'b1;
    mul_a     = '0;
    case (state_q)
      mmh_pkg::BK_INIT: mul_a = ent_q.total_length;
      mmh_pkg::BK_K1:   mul_a = ent_q.data_word;
      mmh_pkg::BK_K2:   mul_a = k_q;
      mmh_pkg::BK_H1:   mul_a = h_q ^ k_q;
      mmh_pkg::BK_TAIL: mul_a = h_q ^ ent_q.data_word;
      mmh_pkg::BK_FIN:  mul_a = mmh_pkg::fold(h_q);
      default:          mul_state = 1'b0;
    endcase
    mul_start = mul_state && !pend_q;

    state_d = state_q;
    case (state_q)
      mmh_pkg::BK_IDLE: if (q_valid_i) begin
        state_d = q_ent_i.is_first ? mmh_pkg::BK_INIT : after_init(q_ent_i);
      end
      mmh_pkg::BK_INIT: if (mul_done) state_d = after_init(ent_q);
      mmh_pkg::BK_K1:   if (mul_done) state_d = mmh_pkg::BK_K2;
      mmh_pkg::BK_K2:   if (mul_done) state_d = mmh_pkg::BK_H1;
      mmh_pkg::BK_H1:   if (mul_done) begin
        state_d = ent_q.is_last ? mmh_pkg::BK_FIN : mmh_pkg::BK_IDLE;
      end
      mmh_pkg::BK_TAIL: if (mul_done) state_d = mmh_pkg::BK_FIN;
      mmh_pkg::BK_FIN:  if (mul_done) state_d = mmh_pkg::BK_OUT;
      mmh_pkg::BK_OUT:  if (out_free) state_d = mmh_pkg::BK_IDLE;
      default:          state_d = mmh_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mmh_pkg::BK_IDLE;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      seed_q      <= 64'd0;
      h_q         <= 64'd0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        seed_q <= cfg_wdata_i;
      end
      if (mul_done) begin
        pend_q <= 1'b0;
      end else if (mul_start) begin
        pend_q <= 1'b1;
      end
      if (state_q == mmh_pkg::BK_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ch_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == mmh_pkg::BK_OUT && out_free) begin
        h_q <= 64'd0;
      end else if (mul_done) begin
        case (state_q)
          mmh_pkg::BK_INIT: h_q <= seed_q ^ mul_p;
          mmh_pkg::BK_H1,
          mmh_pkg::BK_TAIL: h_q <= mul_p;
          default:          h_q <= h_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ent_q <= q_ent_i;
    end
    if (mul_done) begin
      case (state_q)
        mmh_pkg::BK_K1:  k_q <= mmh_pkg::fold(mul_p);
        mmh_pkg::BK_K2,
        mmh_pkg::BK_FIN: k_q <= mul_p;
        default:         k_q <= k_q;
      endcase
    end
    if (state_q == mmh_pkg::BK_OUT && out_free) begin
      out_hash_q <= mmh_pkg::fold(k_q);
      out_mis_q  <= ent_q.length_mismatch;
    end
  end

  assign out_ch_o.valid           = out_valid_q;
  assign out_ch_o.hash_value      = out_hash_q;
  assign out_ch_o.length_mismatch = out_mis_q;

endmodule
